### rtl/bt_uart_pkg.sv
// ----------------------------------------------------------------------------
// bt_uart_pkg
// Shared types and constants of the bit-tick UART transceiver.
// ----------------------------------------------------------------------------
package bt_uart_pkg;

	localparam int DATA_BITS = 8;

	// tx/rx bit phases
	localparam logic [3:0] PH_START = 4'd0;
	localparam logic [3:0] PH_STOP  = 4'd9;
	localparam logic [3:0] PH_DONE  = 4'd10;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_LOAD = 2'd1,
		OP_EDGE = 2'd2,
		OP_READ = 2'd3
	} op_kind_t;

	typedef struct packed {
		op_kind_t               kind;
		logic                   rx_line;
		logic [DATA_BITS-1:0]   data;
		logic                   last_byte;
	} op_t;

	typedef struct packed {
		logic                   tx_line;
		logic                   tx_busy;
		logic [4:0]             rx_count;
		logic [DATA_BITS-1:0]   rx_byte;
		logic                   rx_valid;
		logic                   status;
	} result_t;

endpackage

### rtl/bt_uart_ram.sv
// ----------------------------------------------------------------------------
// bt_uart_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bt_uart_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/bt_uart_front.sv
// ----------------------------------------------------------------------------
// bt_uart_front
// Accepts input words, decodes the mode and queues operations (2 deep).
// ----------------------------------------------------------------------------
module bt_uart_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,
	input  logic [1:0]          s_tuser,
	input  logic                s_tlast,
	output logic                op_valid,
	output bt_uart_pkg::op_t    op,
	input  logic                op_pop
);
	import bt_uart_pkg::*;

	op_t        q_mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	op_t        op_in;
	logic       push;
	logic       pop;

	always_comb begin
		op_in.kind      = op_kind_t'(s_tuser);
		op_in.rx_line   = s_tdata[0];
		op_in.data      = s_tdata[DATA_BITS:1];
		op_in.last_byte = s_tlast;
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign op_valid = (cnt_q != 2'd0);
	assign pop      = op_pop && op_valid;
	assign op       = q_mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### rtl/bt_uart_back.sv
// ----------------------------------------------------------------------------
// bt_uart_back
// Executes queued operations: transmit framer, receive sampler, byte stores,
// and the registered result word.
// ----------------------------------------------------------------------------
module bt_uart_back #(
	parameter int TX_DEPTH = 32,
	parameter int RX_DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	input  logic                  op_valid,
	input  bt_uart_pkg::op_t      op,
	output logic                  op_pop,
	output logic                  res_valid,
	output bt_uart_pkg::result_t  res,
	input  logic                  res_ready
);
	import bt_uart_pkg::*;

	localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam int TX_FW = $clog2(TX_DEPTH + 1);
	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int RX_SW = $clog2(RX_DEPTH);

	// tx state
	logic [TX_FW-1:0]     tx_fill_q, tx_fill_d;
	logic [TX_FW-1:0]     tx_pos_q, tx_pos_d;
	logic [3:0]           tx_phase_q, tx_phase_d;
	logic                 tx_active_q, tx_active_d;
	logic                 tx_level_q, tx_level_d;
	logic                 tx_we;
	logic [DATA_BITS-1:0] tx_rd;
	logic [3:0]           tx_pm1;
	logic [TX_FW-1:0]     tx_pos_inc;

	// rx state
	logic [RX_AW-1:0]     rx_head_q, rx_head_d;
	logic [RX_SW-1:0]     rx_stored_q, rx_stored_d;
	logic [3:0]           rx_phase_q, rx_phase_d;
	logic                 rx_armed_q, rx_armed_d;
	logic [DATA_BITS-1:0] rx_shift_q, rx_shift_d;
	logic                 rx_en_q;
	logic                 rx_we;
	logic [RX_AW:0]       rx_slot_sum;
	logic [RX_AW-1:0]     rx_slot;
	logic [DATA_BITS-1:0] rx_rd;
	logic [DATA_BITS-1:0] rx_byte_now;
	logic                 byp_hit_q;
	logic [DATA_BITS-1:0] byp_data_q;
	logic [31:0]          rx_cnt_ext;

	logic                 go;
	result_t              res_d;
	result_t              res_q;
	logic                 res_valid_q;

	assign go     = op_valid && (!res_valid_q || res_ready);
	assign op_pop = go;

	assign tx_pm1     = tx_phase_q - 4'd1;
	assign tx_pos_inc = tx_pos_q + TX_FW'(1);

	assign rx_slot_sum = {1'b0, rx_head_q} + (RX_AW + 1)'(rx_stored_q);
	assign rx_slot     = (rx_slot_sum >= (RX_AW + 1)'(RX_DEPTH)) ?
		RX_AW'(rx_slot_sum - (RX_AW + 1)'(RX_DEPTH)) : rx_slot_sum[RX_AW-1:0];
	assign rx_byte_now = byp_hit_q ? byp_data_q : rx_rd;

	always_comb begin
		tx_fill_d   = tx_fill_q;
		tx_pos_d    = tx_pos_q;
		tx_phase_d  = tx_phase_q;
		tx_active_d = tx_active_q;
		tx_level_d  = tx_level_q;
		tx_we       = 1'b0;
		rx_head_d   = rx_head_q;
		rx_stored_d = rx_stored_q;
		rx_phase_d  = rx_phase_q;
		rx_armed_d  = rx_armed_q;
		rx_shift_d  = rx_shift_q;
		rx_we       = 1'b0;
		res_d       = '0;

		if (go) begin
			case (op.kind)
				OP_TICK: begin
					if (tx_active_q) begin
						if (tx_phase_q == PH_START) begin
							tx_level_d = 1'b0;
							tx_phase_d = 4'd1;
						end else if (tx_phase_q < PH_STOP) begin
							tx_level_d = tx_rd[tx_pm1[2:0]];
							tx_phase_d = tx_phase_q + 4'd1;
						end else if (tx_phase_q == PH_STOP) begin
							tx_level_d = 1'b1;
							tx_phase_d = PH_DONE;
						end else begin
							tx_phase_d = PH_START;
							tx_pos_d   = tx_pos_inc;
							if (tx_pos_inc >= tx_fill_q) begin
								tx_active_d = 1'b0;
								tx_fill_d   = '0;
								tx_pos_d    = '0;
							end
						end
					end
					if (rx_armed_q && rx_en_q) begin
						if (rx_phase_q == PH_START) begin
							if (!op.rx_line) begin
								rx_phase_d = 4'd1;
							end
						end else if (rx_phase_q < PH_STOP) begin
							rx_shift_d = {op.rx_line, rx_shift_q[DATA_BITS-1:1]};
							rx_phase_d = rx_phase_q + 4'd1;
						end else begin
							rx_phase_d = PH_START;
							rx_armed_d = 1'b0;
							if (op.rx_line && (rx_stored_q < RX_SW'(RX_DEPTH - 1))) begin
								rx_we       = 1'b1;
								rx_stored_d = rx_stored_q + RX_SW'(1);
							end
						end
					end
				end
				OP_LOAD: begin
					if (tx_active_q) begin
						res_d.status = 1'b1;
					end else begin
						if (tx_fill_q < TX_FW'(TX_DEPTH)) begin
							tx_we     = 1'b1;
							tx_fill_d = tx_fill_q + TX_FW'(1);
						end else begin
							res_d.status = 1'b1;
						end
						if (op.last_byte && (tx_fill_d != '0)) begin
							tx_active_d = 1'b1;
							tx_pos_d    = '0;
							tx_phase_d  = PH_START;
						end
					end
				end
				OP_EDGE: begin
					if (!rx_armed_q && rx_en_q) begin
						rx_armed_d = 1'b1;
					end
				end
				OP_READ: begin
					if (rx_stored_q == '0) begin
						res_d.status = 1'b1;
					end else begin
						res_d.rx_byte  = rx_byte_now;
						res_d.rx_valid = 1'b1;
						rx_head_d      = (rx_head_q == RX_AW'(RX_DEPTH - 1)) ?
							'0 : rx_head_q + RX_AW'(1);
						rx_stored_d    = rx_stored_q - RX_SW'(1);
					end
				end
				default: begin
				end
			endcase
		end

		rx_cnt_ext     = 32'(rx_stored_d);
		res_d.tx_line  = tx_level_d;
		res_d.tx_busy  = tx_active_d;
		res_d.rx_count = rx_cnt_ext[4:0];
	end

	bt_uart_ram #(
		.WIDTH (DATA_BITS),
		.DEPTH (TX_DEPTH)
	) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_fill_q[TX_AW-1:0]),
		.wdata (op.data),
		.raddr (tx_pos_d[TX_AW-1:0]),
		.rdata (tx_rd)
	);

	bt_uart_ram #(
		.WIDTH (DATA_BITS),
		.DEPTH (RX_DEPTH)
	) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_slot),
		.wdata (rx_shift_q),
		.raddr (rx_head_d),
		.rdata (rx_rd)
	);

	always_ff @(posedge clk) begin
		byp_data_q <= rx_shift_q;
		rx_shift_q <= rx_shift_d;
		if (go) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_fill_q   <= '0;
			tx_pos_q    <= '0;
			tx_phase_q  <= PH_START;
			tx_active_q <= 1'b0;
			tx_level_q  <= 1'b1;
			rx_head_q   <= '0;
			rx_stored_q <= '0;
			rx_phase_q  <= PH_START;
			rx_armed_q  <= 1'b0;
			rx_en_q     <= 1'b0;
			byp_hit_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			tx_fill_q   <= tx_fill_d;
			tx_pos_q    <= tx_pos_d;
			tx_phase_q  <= tx_phase_d;
			tx_active_q <= tx_active_d;
			tx_level_q  <= tx_level_d;
			rx_head_q   <= rx_head_d;
			rx_stored_q <= rx_stored_d;
			rx_phase_q  <= rx_phase_d;
			rx_armed_q  <= rx_armed_d;
			// write landing on the next read address: the registered RAM read still returns the old data
			byp_hit_q   <= rx_we && (rx_slot == rx_head_d);
			if (cfg_we) begin
				rx_en_q <= cfg_wdata;
			end
			if (go) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### rtl/bit_tick_uart_transceiver.sv
// ----------------------------------------------------------------------------
// bit_tick_uart_transceiver
// 8N1 UART transceiver advanced by one bit tick word per baud period.
// ----------------------------------------------------------------------------
// Input stream (s_*): one word per operation, kind in s_tuser: bit tick,
// load transmit byte (s_tlast marks the last byte and starts sending),
// receive start edge, read received byte. Output stream (m_*): exactly one
// result word per input word, in order.
// Config: cfg_we/cfg_wdata write rx_enable; write only while idle.
// An accepted word waits in the queue, then its result is registered onto m_*.
// Throughput: one word per cycle unless m_tready stalls; every operation finishes in a single pass
// of the execute stage, with byte stores in registered-read RAMs that are
// prefetched at the next transmit position and receive head.
// A 2-word queue sits between decode and execute; when m_tready is low the
// result register holds and the queue absorbs up to two more words before
// s_tready drops.
// Reset: transmit line idle high, transmitter idle with an empty buffer,
// receiver disarmed and disabled, receive store empty. Store contents are
// not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bit_tick_uart_transceiver #(
	parameter int TX_DEPTH = 32,
	parameter int RX_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // rx_line[0], data[8:1], zero[15:9]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // tx_line[0], tx_busy[1], rx_count[6:2], rx_byte[14:7]
	output logic [1:0]  m_tuser    // rx_valid[0], status[1]
);
	import bt_uart_pkg::*;

	logic    op_valid;
	op_t     op;
	logic    op_pop;
	result_t res;

	bt_uart_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.op_valid (op_valid),
		.op       (op),
		.op_pop   (op_pop)
	);

	bt_uart_back #(
		.TX_DEPTH (TX_DEPTH),
		.RX_DEPTH (RX_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op_valid  (op_valid),
		.op        (op),
		.op_pop    (op_pop),
		.res_valid (m_tvalid),
		.res       (res),
		.res_ready (m_tready)
	);

	assign m_tdata = {1'b0, res.rx_byte, res.rx_count, res.tx_busy, res.tx_line};
	assign m_tuser = {res.status, res.rx_valid};

endmodule

### tb/tb_bit_tick_uart_transceiver.sv
// ----------------------------------------------------------------------------
// tb_bit_tick_uart_transceiver
// Stream-level test of the bit-tick 8N1 UART transceiver. A cycle-free
// predictor follows every accepted word and queues the result word it must
// produce; a monitor compares each result word field by field. Directed
// transmit and receive sequences, buffer limits, a long output stall and
// random well-formed traffic mixed with noise are run, mostly under random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bit_tick_uart_transceiver;
	import bt_uart_pkg::*;

	localparam int TXD          = 32;
	localparam int RXD          = 32;
	localparam int RANDOM_WORDS = 730;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;

	bit_tick_uart_transceiver #(
		.TX_DEPTH (TXD),
		.RX_DEPTH (RXD)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// predictor state
	logic [7:0] tx_buf [TXD];
	logic [5:0] tx_fill   = '0;
	logic [5:0] tx_pos    = '0;
	logic [3:0] tx_phase  = PH_START;
	logic       tx_on     = 1'b0;
	logic       tx_lvl    = 1'b1;
	logic [7:0] rx_buf [RXD];
	logic [4:0] rx_head   = '0;
	logic [4:0] rx_kept   = '0;
	logic [3:0] rx_phase  = PH_START;
	logic       rx_armed  = 1'b0;
	logic       rx_en     = 1'b0;

	result_t due_results [$];
	int      fail_count  = 0;
	int      words_sent  = 0;
	int      cycle_count = 0;
	bit      tx_idle_on  = 1'b1;
	bit      rx_idle_on  = 1'b1;
	bit      hold_req    = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic result_t uart_next_result(op_kind_t kind, logic rx_lvl,
			logic [7:0] din, logic last);
		result_t    r;
		logic [4:0] slot;
		r = '0;
		case (kind)
			OP_TICK: begin
				if (tx_on) begin
					if (tx_phase == PH_START) begin
						tx_lvl   = 1'b0;
						tx_phase = 4'd1;
					end else if (tx_phase < PH_STOP) begin
						tx_lvl   = tx_buf[tx_pos][tx_phase - 1];
						tx_phase = tx_phase + 4'd1;
					end else if (tx_phase == PH_STOP) begin
						tx_lvl   = 1'b1;
						tx_phase = PH_DONE;
					end else begin
						tx_phase = PH_START;
						tx_pos   = tx_pos + 6'd1;
						if (tx_pos >= tx_fill) begin
							tx_on   = 1'b0;
							tx_fill = '0;
							tx_pos  = '0;
						end
					end
				end
				slot = rx_head + rx_kept;
				if (rx_armed && rx_en) begin
					if (rx_phase == PH_START) begin
						if (!rx_lvl) begin
							rx_phase     = 4'd1;
							rx_buf[slot] = '0;
						end
					end else if (rx_phase < PH_STOP) begin
						rx_buf[slot][rx_phase - 1] = rx_lvl;
						rx_phase = rx_phase + 4'd1;
					end else begin
						rx_phase = PH_START;
						rx_armed = 1'b0;
						if (rx_lvl && rx_kept < RXD - 1)
							rx_kept = rx_kept + 5'd1;
					end
				end
			end
			OP_LOAD: begin
				if (tx_on) begin
					r.status = 1'b1;
				end else begin
					if (tx_fill < TXD) begin
						tx_buf[tx_fill] = din;
						tx_fill = tx_fill + 6'd1;
					end else begin
						r.status = 1'b1;
					end
					if (last && tx_fill > 0) begin
						tx_on    = 1'b1;
						tx_pos   = '0;
						tx_phase = PH_START;
					end
				end
			end
			OP_EDGE: begin
				if (!rx_armed && rx_en)
					rx_armed = 1'b1;
			end
			default: begin
				if (rx_kept == 0) begin
					r.status = 1'b1;
				end else begin
					r.rx_byte  = rx_buf[rx_head];
					r.rx_valid = 1'b1;
					rx_head    = rx_head + 5'd1;
					rx_kept    = rx_kept - 5'd1;
				end
			end
		endcase
		r.tx_line  = tx_lvl;
		r.tx_busy  = tx_on;
		r.rx_count = rx_kept;
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : result_monitor
		result_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (due_results.size() == 0) begin
				$error("result word with nothing pending");
				fail_count++;
			end else begin
				want = due_results.pop_front();
				check_field("tx_line", want.tx_line, m_tdata[0]);
				check_field("tx_busy", want.tx_busy, m_tdata[1]);
				check_field("rx_count", want.rx_count, m_tdata[6:2]);
				check_field("rx_byte", want.rx_byte, m_tdata[14:7]);
				check_field("rx_valid", want.rx_valid, m_tuser[0]);
				check_field("status", want.status, m_tuser[1]);
			end
		end
	end

	// output side: random stalls, plus one long hold on request
	initial begin : result_sink
		int i;
		m_tready = 1'b0;
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				for (i = 0; i < HOLD_CYCLES; i++)
					@(posedge clk);
				hold_req = 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_word(op_kind_t kind, logic rx_lvl, logic [7:0] din, logic last);
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {7'b0, din, rx_lvl};
		s_tlast  <= last;
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		due_results.push_back(uart_next_result(kind, rx_lvl, din, last));
		words_sent++;
	endtask

	task automatic tick(logic rx_lvl);
		send_word(OP_TICK, rx_lvl, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	task automatic load(logic [7:0] din, logic last);
		send_word(OP_LOAD, 1'($urandom_range(0, 1)), din, last);
	endtask

	task automatic read_byte();
		send_word(OP_READ, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)));
	endtask

	task automatic start_edge();
		send_word(OP_EDGE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)));
	endtask

	task automatic rx_frame(logic [7:0] bits, logic stop);
		int i;
		start_edge();
		tick(1'b0);
		for (i = 0; i < 8; i++)
			tick(bits[i]);
		tick(stop);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_rx_enable(logic v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		rx_en     = v;
	endtask

	// receiver still disabled from reset
	task automatic test_tx_basic();
		int i;
		read_byte();
		start_edge();
		load(8'hA5, 1'b1);
		load(8'h3C, 1'b0);
		for (i = 0; i < 11; i++)
			tick(1'($urandom_range(0, 1)));
	endtask

	// one frame with a disable in the middle of it
	task automatic test_rx_basic();
		int i;
		logic [7:0] bits;
		bits = 8'h81;
		set_rx_enable(1'b1);
		start_edge();
		tick(1'b1);
		tick(1'b0);
		for (i = 0; i < 8; i++) begin
			if (i == 3) begin
				set_rx_enable(1'b0);
				tick(1'b0);
				start_edge();
				set_rx_enable(1'b1);
				start_edge();
			end
			tick(bits[i]);
		end
		tick(1'b1);
	endtask

	// full transmit buffer, receive store overflow, bad stop, drain by reads
	task automatic test_buffer_limits();
		int i;
		logic [7:0] d;
		for (i = 0; i < TXD; i++) begin
			d = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(0, 255));
			load(d, 1'b0);
		end
		load(8'($urandom_range(0, 255)), 1'b1);
		load(8'($urandom_range(0, 255)), 1'b1);
		for (i = 0; i < RXD + 2; i++) begin
			d = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(0, 255));
			rx_frame(d, i != 5);
		end
		while (tx_on)
			tick(1'b1);
		for (i = 0; i < RXD + 1; i++)
			read_byte();
	endtask

	task automatic test_pressure();
		int i;
		drain();
		hold_req   = 1'b1;
		tx_idle_on = 1'b0;
		for (i = 0; i < 40; i++)
			send_word(op_kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		tx_idle_on = 1'b1;
	endtask

	task automatic test_random();
		int first;
		int next_cfg;
		int pick;
		int n;
		int i;
		first    = words_sent;
		next_cfg = first + 200;
		while (words_sent < first + RANDOM_WORDS) begin
			if (words_sent >= first + RANDOM_WORDS - 250) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end
			if (words_sent >= next_cfg) begin
				next_cfg = words_sent + 200;
				set_rx_enable($urandom_range(0, 4) != 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				rx_frame(8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0);
			end else if (pick < 55) begin
				n = ($urandom_range(0, 15) == 0) ? $urandom_range(4, TXD + 1)
					: $urandom_range(1, 3);
				for (i = 0; i < n; i++)
					load(8'($urandom_range(0, 255)), i == n - 1);
			end else if (pick < 75) begin
				n = $urandom_range(1, 12);
				for (i = 0; i < n; i++)
					tick(1'($urandom_range(0, 1)));
			end else if (pick < 90) begin
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++)
					read_byte();
			end else if (pick < 95) begin
				// broken frame
				start_edge();
				tick(1'b0);
				n = $urandom_range(0, 7);
				for (i = 0; i < n; i++)
					tick(1'($urandom_range(0, 1)));
			end else begin
				send_word(op_kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = OP_TICK;
		s_tlast   = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_tx_basic();
		test_rx_basic();
		test_buffer_limits();
		test_pressure();
		test_random();
		drain();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/bt_uart_pkg.sv
rtl/bt_uart_ram.sv
rtl/bt_uart_front.sv
rtl/bt_uart_back.sv
rtl/bit_tick_uart_transceiver.sv
tb/tb_bit_tick_uart_transceiver.sv
